### rtl/core/pireg_pkg.sv
// ----------------------------------------------------------------------------
// PI regulator package
// Field widths, loop limits, sequencing constants and register indexes.
// ----------------------------------------------------------------------------
package pireg_pkg;

  // Field widths
  localparam int IN_W    = 16;   // feedback / reference
  localparam int GAIN_W  = 16;   // kp / ki
  localparam int DRIVE_W = 11;   // drive output
  localparam int CFG_W   = 16;   // widest configuration register

  // Internal widths
  localparam int ERR_W  = IN_W + 1;   // reference - feedback
  localparam int SUM_W  = 21;         // parallel error sum
  localparam int MC_W   = 33;         // multiplicand: |kp*err| < 2^32
  localparam int PROD_W = MC_W + GAIN_W;  // serial product
  localparam int INT_W  = PROD_W + 1;     // series integral term
  localparam int RAW_W  = INT_W + 1;      // unclamped output
  localparam int MAG_W  = 24;             // |clamped output| <= 1e7
  localparam int QUO_W  = 10;             // quotient <= 1000

  // Serial multiplier digit
  localparam int DIG_W     = 4;
  localparam int MUL_STEPS = GAIN_W / DIG_W;
  localparam int DIV_STEPS = QUO_W;

  // Loop limits
  localparam int SUM_LIMIT = 1000000;
  localparam int OUT_LIMIT = 10000000;
  localparam int OUT_SCALE = 10000;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_KP   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KI   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FORM = 2'd2;

  // Controller forms
  localparam logic FORM_PARALLEL = 1'b0;
  localparam logic FORM_SERIES   = 1'b1;

endpackage

### rtl/core/pi_regulator_clamped_top.sv
// ----------------------------------------------------------------------------
// Sequencing: an accepted request passes a prepare step, two digit-serial
// multiplies with a 4-bit digit, an add step, a clamp step and a bit-serial
// divide by 10000, then a done step that loads the output register; a clear
// goes straight to the done step. Only one request is in flight at a time, and
// a finished result waits in the done step until the output register is free.
// Reset clears gains, form, error sum, integral term and windup enable.
// ----------------------------------------------------------------------------
// ----------------------------------------------------------------------------
// PI regulator with clamped output and anti-windup
// Parallel or series integer PI controller, digit-serial datapath.
// ----------------------------------------------------------------------------
module pi_regulator_clamped_top (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // configuration
  input  logic                                   cfg_we_i,
  input  logic [pireg_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [pireg_pkg::CFG_W-1:0]            cfg_wdata_i,
  // request channel
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic signed [pireg_pkg::IN_W-1:0]      feedback_i,
  input  logic signed [pireg_pkg::IN_W-1:0]      reference_i,
  input  logic                                   clear_i,
  // result channel
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic signed [pireg_pkg::DRIVE_W-1:0]   drive_o,
  output logic                                   saturated_o
);
  import pireg_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_MUL1,
    S_MUL2,
    S_ADD,
    S_CLAMP,
    S_DIV,
    S_DONE
  } state_e;

  localparam logic [MAG_W-1:0] DIV_START = MAG_W'(OUT_SCALE) << (QUO_W - 1);

  state_e                    state_q;
  logic [GAIN_W-1:0]         kp_q, ki_q;
  logic                      form_q;
  logic signed [SUM_W-1:0]   err_accum_q;
  logic signed [INT_W-1:0]   integ_q;
  logic                      windup_q;

  logic signed [ERR_W-1:0]   err_q;
  logic signed [MC_W-1:0]    mc_q;
  logic [GAIN_W-1:0]         dig_q;
  logic signed [MC_W-1:0]    acc_q;
  logic [GAIN_W-1:0]         lo_q;
  logic [3:0]                cnt_q;
  logic signed [PROD_W-1:0]  p_q;
  logic signed [INT_W-1:0]   q_q;
  logic [MAG_W-1:0]          rem_q;
  logic [MAG_W-1:0]          dv_q;
  logic [QUO_W-1:0]          quo_q;
  logic                      neg_q;
  logic                      sat_res_q;

  logic                      out_valid_q;
  logic signed [DRIVE_W-1:0] drive_q;
  logic                      sat_out_q;

  logic                      in_acc;
  logic                      out_free;
  logic signed [ERR_W-1:0]   err_d;
  logic signed [SUM_W:0]     sum_ext;
  logic signed [SUM_W-1:0]   sum_clamped;
  logic signed [MC_W+DIG_W:0] pp;
  logic signed [MC_W+DIG_W:0] step_sum;
  logic signed [MC_W-1:0]    acc_d;
  logic [GAIN_W-1:0]         lo_d;
  logic signed [PROD_W-1:0]  prod;
  logic signed [INT_W-1:0]   integ_new;
  logic signed [RAW_W-1:0]   raw;
  logic signed [RAW_W-1:0]   raw_abs;
  logic                      raw_hi, raw_lo;
  logic [MAG_W-1:0]          mag;
  logic [QUO_W:0]            quo_ext;

  assign in_acc     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;

  always_comb begin
    err_d = ERR_W'(reference_i) - ERR_W'(feedback_i);

    // clamp the running sum
    sum_ext = (SUM_W+1)'(err_accum_q) + (SUM_W+1)'(err_q);
    if (sum_ext > (SUM_W+1)'(SUM_LIMIT)) begin
      sum_clamped = SUM_W'(SUM_LIMIT);
    end else if (sum_ext < -(SUM_W+1)'(SUM_LIMIT)) begin
      sum_clamped = -SUM_W'(SUM_LIMIT);
    end else begin
      sum_clamped = sum_ext[SUM_W-1:0];
    end

    // one digit of the serial multiplier, least significant first
    pp       = (MC_W+DIG_W+1)'(mc_q) * (MC_W+DIG_W+1)'($signed({1'b0, dig_q[DIG_W-1:0]}));
    step_sum = pp + (MC_W+DIG_W+1)'(acc_q);
    acc_d    = step_sum[MC_W+DIG_W-1:DIG_W];
    lo_d     = {step_sum[DIG_W-1:0], lo_q[GAIN_W-1:DIG_W]};
    prod     = {acc_d, lo_d};

    integ_new = windup_q ? (INT_W'(q_q) + integ_q) : '0;

    raw     = RAW_W'(p_q) + RAW_W'(q_q);
    raw_hi  = raw > RAW_W'(OUT_LIMIT);
    raw_lo  = raw < -RAW_W'(OUT_LIMIT);
    raw_abs = raw[RAW_W-1] ? -raw : raw;
    mag     = (raw_hi || raw_lo) ? MAG_W'(OUT_LIMIT) : raw_abs[MAG_W-1:0];

    quo_ext = {1'b0, quo_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      kp_q        <= '0;
      ki_q        <= '0;
      form_q      <= FORM_PARALLEL;
      err_accum_q <= '0;
      integ_q     <= '0;
      windup_q    <= 1'b0;
      out_valid_q <= 1'b0;
      drive_q     <= '0;
      sat_out_q   <= 1'b0;
      err_q       <= '0;
      mc_q        <= '0;
      dig_q       <= '0;
      acc_q       <= '0;
      lo_q        <= '0;
      cnt_q       <= '0;
      p_q         <= '0;
      q_q         <= '0;
      rem_q       <= '0;
      dv_q        <= '0;
      quo_q       <= '0;
      neg_q       <= 1'b0;
      sat_res_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_KP:   kp_q   <= cfg_wdata_i[GAIN_W-1:0];
          CFG_KI:   ki_q   <= cfg_wdata_i[GAIN_W-1:0];
          CFG_FORM: form_q <= cfg_wdata_i[0];
          default:  ;
        endcase
      end

      // drop the result once taken, unless a new one replaces it
      if (out_valid_q && !out_stall_i && (state_q != S_DONE)) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            err_q <= err_d;
            if (clear_i) begin
              err_accum_q <= '0;
              quo_q       <= '0;
              neg_q       <= 1'b0;
              sat_res_q   <= 1'b0;
              state_q     <= S_DONE;
            end else begin
              state_q <= S_PREP;
            end
          end
        end
        S_PREP: begin
          if (form_q == FORM_PARALLEL) begin
            err_accum_q <= sum_clamped;
          end
          mc_q    <= MC_W'(err_q);
          dig_q   <= kp_q;
          acc_q   <= '0;
          cnt_q   <= '0;
          state_q <= S_MUL1;
        end
        S_MUL1, S_MUL2: begin
          lo_q <= lo_d;
          if (cnt_q == 4'(MUL_STEPS - 1)) begin
            cnt_q <= '0;
            acc_q <= '0;
            if (state_q == S_MUL1) begin
              p_q   <= prod;
              dig_q <= ki_q;
              // series form multiplies p, parallel form the error sum
              mc_q  <= (form_q == FORM_SERIES) ? prod[MC_W-1:0] : MC_W'(err_accum_q);
              state_q <= S_MUL2;
            end else begin
              q_q     <= INT_W'(prod);
              state_q <= S_ADD;
            end
          end else begin
            acc_q <= acc_d;
            dig_q <= dig_q >> DIG_W;
            cnt_q <= cnt_q + 4'd1;
          end
        end
        S_ADD: begin
          if (form_q == FORM_SERIES) begin
            q_q     <= integ_new;
            integ_q <= integ_new;
          end
          state_q <= S_CLAMP;
        end
        S_CLAMP: begin
          sat_res_q <= raw_hi || raw_lo;
          if (form_q == FORM_SERIES) begin
            windup_q <= !(raw_hi || raw_lo);
          end
          neg_q   <= raw[RAW_W-1];
          rem_q   <= mag;
          dv_q    <= DIV_START;
          quo_q   <= '0;
          cnt_q   <= '0;
          state_q <= S_DIV;
        end
        S_DIV: begin
          // restoring divide, one quotient bit per cycle
          if (rem_q >= dv_q) begin
            rem_q <= rem_q - dv_q;
            quo_q <= {quo_q[QUO_W-2:0], 1'b1};
          end else begin
            quo_q <= {quo_q[QUO_W-2:0], 1'b0};
          end
          dv_q <= dv_q >> 1;
          if (cnt_q == 4'(DIV_STEPS - 1)) begin
            cnt_q   <= '0;
            state_q <= S_DONE;
          end else begin
            cnt_q <= cnt_q + 4'd1;
          end
        end
        S_DONE: begin
          if (out_free) begin
            drive_q     <= neg_q ? -DRIVE_W'(quo_ext) : DRIVE_W'(quo_ext);
            sat_out_q   <= sat_res_q;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign drive_o     = drive_q;
  assign saturated_o = sat_out_q;

  // A request always leaves the core busy in the cycle after it is accepted
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> in_stall_o)
    else $error("request accepted but core not busy");

  // A saturated result sits at the full scale of the drive range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && saturated_o) |->
      (drive_o == DRIVE_W'(OUT_LIMIT / OUT_SCALE)) ||
      (drive_o == -DRIVE_W'(OUT_LIMIT / OUT_SCALE)))
    else $error("saturated result off full scale");

  // The parallel error sum never leaves its clamp
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (err_accum_q <= SUM_W'(SUM_LIMIT)) && (err_accum_q >= -SUM_W'(SUM_LIMIT)))
    else $error("error sum outside clamp");

  // The integral term only advances in the add step of the series form
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_ADD) |=> $stable(integ_q))
    else $error("integral term changed outside its update step");

endmodule

### verif/tb_pi_regulator_clamped_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// PI regulator testbench
// Drives feedback/reference requests through the parallel and series forms
// under random gaps and stalls. A scoreboard class predicts every drive value
// and saturation flag and checks the results in order.
// ----------------------------------------------------------------------------
module tb_pi_regulator_clamped_top;
  import pireg_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int SEGMENTS    = 5;
  localparam int SEG_ITEMS   = 30;
  localparam int SETTLE      = 30;
  localparam int REPORT_MAX  = 10;

  // index past the last register: the block must ignore it
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  typedef struct packed {
    logic signed [DRIVE_W-1:0] drive;
    logic                      saturated;
  } drive_result_t;

  class pi_drive_scoreboard;
    logic [GAIN_W-1:0] kp_gain;
    logic [GAIN_W-1:0] ki_gain;
    logic              form_sel;
    longint            err_accum;
    longint            integ_prev;
    bit                windup_en;
    drive_result_t     expected_q[$];
    int unsigned       failures;

    function new();
      kp_gain    = '0;
      ki_gain    = '0;
      form_sel   = FORM_PARALLEL;
      err_accum  = 0;
      integ_prev = 0;
      windup_en  = 1'b0;
      failures   = 0;
    endfunction

    function void flag(string msg);
      failures++;
      if (failures <= REPORT_MAX) $display("%s", msg);
    endfunction

    function void apply_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        CFG_KP:   kp_gain = data[GAIN_W-1:0];
        CFG_KI:   ki_gain = data[GAIN_W-1:0];
        CFG_FORM: form_sel = data[0];
        default: ;
      endcase
    endfunction

    function longint clamp_output(input longint v, output bit hit);
      hit = 1'b0;
      if (v > OUT_LIMIT) begin
        hit = 1'b1;
        return OUT_LIMIT;
      end
      if (v < -OUT_LIMIT) begin
        hit = 1'b1;
        return -OUT_LIMIT;
      end
      return v;
    endfunction

    function void note_sample(logic signed [IN_W-1:0] fb, logic signed [IN_W-1:0] rf,
                              logic clr);
      longint        err;
      longint        sum_next;
      longint        prop;
      longint        integ;
      longint        held;
      bit            sat;
      drive_result_t res;
      err = longint'(rf) - longint'(fb);
      if (clr) begin
        err_accum     = 0;
        res.drive     = '0;
        res.saturated = 1'b0;
      end else begin
        if (form_sel == FORM_PARALLEL) begin
          sum_next = err_accum + err;
          if (sum_next > SUM_LIMIT) sum_next = SUM_LIMIT;
          if (sum_next < -SUM_LIMIT) sum_next = -SUM_LIMIT;
          err_accum = sum_next;
          held = clamp_output(longint'(kp_gain) * err + longint'(ki_gain) * sum_next, sat);
        end else begin
          prop  = longint'(kp_gain) * err;
          // integral term only survives while the last output stayed in range
          integ = windup_en ? prop * longint'(ki_gain) + integ_prev : 0;
          held  = clamp_output(prop + integ, sat);
          windup_en  = !sat;
          integ_prev = integ;
        end
        res.drive     = DRIVE_W'(held / OUT_SCALE);
        res.saturated = sat;
      end
      expected_q.push_back(res);
    endfunction

    function void check_drive(logic signed [DRIVE_W-1:0] drive, logic sat);
      drive_result_t exp_res;
      if (expected_q.size() == 0) begin
        flag($sformatf("result with no request outstanding: drive %0d sat %0b", drive, sat));
        return;
      end
      exp_res = expected_q.pop_front();
      if (drive !== exp_res.drive || sat !== exp_res.saturated)
        flag($sformatf("drive mismatch: expected drive %0d sat %0b, got drive %0d sat %0b",
                       exp_res.drive, exp_res.saturated, drive, sat));
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void flag_leftovers();
      drive_result_t exp_res;
      while (expected_q.size() != 0) begin
        exp_res = expected_q.pop_front();
        flag($sformatf("missing result: expected drive %0d sat %0b",
                       exp_res.drive, exp_res.saturated));
      end
    endfunction
  endclass

  logic                        clk_i;
  logic                        rst_ni;
  logic                        cfg_we_i;
  logic [CFG_IDX_W-1:0]        cfg_idx_i;
  logic [CFG_W-1:0]            cfg_wdata_i;
  logic                        in_valid_i;
  logic                        in_stall_o;
  logic signed [IN_W-1:0]      feedback_i;
  logic signed [IN_W-1:0]      reference_i;
  logic                        clear_i;
  logic                        out_valid_o;
  logic                        out_stall_i = 1'b0;
  logic signed [DRIVE_W-1:0]   drive_o;
  logic                        saturated_o;

  int                 sender_gap_pct     = 0;
  int                 receiver_stall_pct = 0;
  int unsigned        cycle_count        = 0;
  pi_drive_scoreboard pi_model;

  pi_regulator_clamped_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .feedback_i  (feedback_i),
    .reference_i (reference_i),
    .clear_i     (clear_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .drive_o     (drive_o),
    .saturated_o (saturated_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    out_stall_i = ($urandom_range(99) < receiver_stall_pct);
  end

  // check results before noting the request taken on the same edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) pi_model.check_drive(drive_o, saturated_o);
      if (in_valid_i && !in_stall_o) pi_model.note_sample(feedback_i, reference_i, clear_i);
      if (cfg_we_i) pi_model.apply_write(cfg_idx_i, cfg_wdata_i);
    end
  end

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_idx_i   = idx;
    cfg_wdata_i = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic send_request(input logic signed [IN_W-1:0] fb,
                              input logic signed [IN_W-1:0] rf, input logic clr);
    @(negedge clk_i);
    while ($urandom_range(99) < sender_gap_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  = 1'b1;
    feedback_i  = fb;
    reference_i = rf;
    clear_i     = clr;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic wait_for_results();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pi_model.pending() != 0) @(negedge clk_i);
  endtask

  function automatic logic [GAIN_W-1:0] pick_gain();
    case ($urandom_range(4))
      0:       return $urandom_range(1) ? '1 : '0;
      1:       return GAIN_W'($urandom_range(63));
      2:       return GAIN_W'($urandom_range(2047));
      3:       return GAIN_W'($urandom);
      default: return GAIN_W'($urandom_range(7));
    endcase
  endfunction

  task automatic run_phase(input int gap_pct, input int stall_pct);
    int   kind;
    int   span;
    int   ref_v;
    int   fb_v;
    logic clr;
    sender_gap_pct     = gap_pct;
    receiver_stall_pct = stall_pct;
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      write_register(CFG_KP, pick_gain());
      write_register(CFG_KI, pick_gain());
      write_register(CFG_FORM, CFG_W'($urandom));
      if ($urandom_range(1)) write_register(CFG_SPARE, CFG_W'($urandom));
      for (int n = 0; n < SEG_ITEMS; n++) begin
        kind  = $urandom_range(99);
        clr   = ($urandom_range(99) < 4);
        ref_v = int'($urandom_range(65535)) - 32768;
        if (kind < 65) begin
          // tracking loop: feedback close to reference
          span = 1 << (4 * $urandom_range(3));
          fb_v = ref_v - (int'($urandom_range(2 * span)) - span);
          if (fb_v > 32767) fb_v = 32767;
          if (fb_v < -32768) fb_v = -32768;
        end else if (kind < 90) begin
          fb_v = int'($urandom_range(65535)) - 32768;
        end else begin
          ref_v = $urandom_range(1) ? 32767 : -32768;
          fb_v  = $urandom_range(1) ? 32767 : -32768;
        end
        send_request(IN_W'(fb_v), IN_W'(ref_v), clr);
      end
      wait_for_results();
    end
  endtask

  initial begin
    pi_model    = new();
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = CFG_KP;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    feedback_i  = '0;
    reference_i = '0;
    clear_i     = 1'b0;
    sender_gap_pct     = 21;
    receiver_stall_pct = 58;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    // parallel form, full gains: both saturation directions, then clear
    write_register(CFG_SPARE, '1);
    write_register(CFG_KP, '1);
    write_register(CFG_KI, '1);
    write_register(CFG_FORM, {{(CFG_W-1){1'b0}}, FORM_PARALLEL});
    send_request(IN_W'(-32768), IN_W'(32767), 1'b0);
    send_request(IN_W'(32767), IN_W'(-32768), 1'b0);
    send_request(IN_W'(0), IN_W'(0), 1'b1);
    wait_for_results();

    // integral only: drive the sum into its limit, output lands on the clamp
    write_register(CFG_KP, '0);
    write_register(CFG_KI, 16'd10);
    repeat (16) send_request(IN_W'(-32768), IN_W'(32767), 1'b0);
    send_request(IN_W'(0), IN_W'(0), 1'b1);
    wait_for_results();

    // series form: negative truncation, windup engage, saturate, release
    write_register(CFG_KP, 16'd1);
    write_register(CFG_KI, '1);
    write_register(CFG_FORM, {{(CFG_W-1){1'b0}}, FORM_SERIES});
    send_request(IN_W'(0), IN_W'(-15000), 1'b0);
    send_request(IN_W'(0), IN_W'(100), 1'b0);
    send_request(IN_W'(-32768), IN_W'(32767), 1'b0);
    send_request(IN_W'(32767), IN_W'(-32768), 1'b0);
    send_request(IN_W'(0), IN_W'(0), 1'b1);
    wait_for_results();

    run_phase(21, 58);
    run_phase(58, 21);
    run_phase(0, 0);

    repeat (SETTLE) @(negedge clk_i);
    pi_model.flag_leftovers();
    if (pi_model.failures == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
